[hw/rtl/fud_pkg.sv]
// Shared types, character codes and the hex digit formula for the form body decoder.
// Depends on nothing; used by every module of the decoder.
package fud_pkg;

   typedef enum logic [1:0] {
      KIND_NAME  = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_PAIR  = 2'd2,
      KIND_END   = 2'd3
   } item_kind_type;

   // escape progress: idle, '%' seen, first digit held
   typedef enum logic [1:0] {
      ESC_IDLE    = 2'd0,
      ESC_PERCENT = 2'd1,
      ESC_HIGH    = 2'd2
   } esc_phase_type;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CASE_MASK    = 8'hdf;
   localparam logic [7:0] LETTER_BASE  = 8'd10;

   // One queue entry: every result one body byte causes, in emission order
   // data byte, end of pair, end of message.
   typedef struct packed {
      logic          has_data;
      item_kind_type data_kind;
      logic [7:0]    data;
      logic          has_pair;
      logic          has_end;
   } entry_type;

   // Unchecked hex digit value, wrapping mod 256.
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CHAR_UPPER_A) begin
         v = (c & CASE_MASK) - CHAR_UPPER_A + LETTER_BASE;
      end else begin
         v = c - CHAR_ZERO;
      end
      return v;
   endfunction

endpackage

[hw/rtl/form_urlencoded_decoder.sv]
// Top level of the streaming form body decoder: front classifier, entry queue, back sequencer.
// Depends on fud_pkg, fud_front, fud_queue and fud_back.
//
// Use: feed the raw form-encoded body one byte per item on the req_ channel, with
// req_tlast high on the final byte. Decoded name and value bytes leave on the rsp_
// channel, tagged by rsp_tuser (name byte, value byte, end of pair, end of message);
// rsp_tlast marks the last result caused by one body byte. Bytes that cause nothing
// ('%', the first digit of an escape, separators of empty pairs, bytes after a zero
// byte) leave no trace on the output.
// Path: a result passes through a queue slot and then the output register before it
// appears on rsp_, also when the queue is empty and the output register is free.
// Throughput: one body byte per cycle while the queue has a free slot; one result per
// cycle on the output while rsp_tready is high. A byte that closes a pair and the message
// yields up to three results, issued one after another; the entry queue absorbs the burst.
// Reset: synchronous, active high; clears the pair and escape state, empties the
// queue and drops any result not yet taken.
// Stalls: with rsp_tready low the output register holds its item, the queue fills,
// and req_tready falls only when the queue has no free slot.
module form_urlencoded_decoder #(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] body_byte
   input  logic       req_tlast,   // body_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] decoded_byte
   output logic [1:0] rsp_tuser,   // [1:0] item_kind
   output logic       rsp_tlast    // last_of_run
);

   fud_pkg::entry_type push_entry;
   fud_pkg::entry_type head;
   logic               push, pop, not_empty, full;

   // classify bytes and build entries
   fud_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (full),
      .push       (push),
      .entry      (push_entry)
   );

   // hold entries while the output side is busy or stalled
   fud_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .full       (full)
   );

   // emit the results of each entry in order
   fud_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (not_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hw/rtl/fud_front.sv]
// Front part of the form body decoder: accepts body bytes, tracks pair and escape state
// and builds one queue entry per byte that causes a result. Depends on fud_pkg.
module fud_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] body_byte
   input  logic                req_tlast,   // body_end
   input  logic                queue_full,
   output logic                push,
   output fud_pkg::entry_type  entry
);

   logic                   pair_open_ff, pair_open_in;
   logic                   in_value_ff, in_value_in;
   fud_pkg::esc_phase_type esc_phase_ff, esc_phase_in;
   logic [7:0]             esc_high_ff, esc_high_in;
   logic                   stopped_ff, stopped_in;

   logic       accept;
   logic       is_zero, is_amp, is_name_eq, is_data;
   logic [7:0] byte_sp;
   logic       pair_open_mid;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // classify the raw byte
   assign is_zero    = !stopped_ff && (req_tdata == fud_pkg::CHAR_NUL);
   assign is_amp     = !stopped_ff && (req_tdata == fud_pkg::CHAR_AMP);
   assign is_name_eq = !stopped_ff && (req_tdata == fud_pkg::CHAR_EQUALS) && !in_value_ff;
   assign is_data    = !stopped_ff && !is_zero && !is_amp && !is_name_eq;
   assign byte_sp    = (req_tdata == fud_pkg::CHAR_PLUS) ? fud_pkg::CHAR_SPACE : req_tdata;

   // pair still open after the byte itself is handled
   assign pair_open_mid = (pair_open_ff && !is_amp) || is_name_eq || is_data;

   // next state
   always_comb begin
      pair_open_in = pair_open_ff;
      in_value_in  = in_value_ff;
      esc_phase_in = esc_phase_ff;
      esc_high_in  = esc_high_ff;
      stopped_in   = stopped_ff;
      if (is_zero) begin
         stopped_in   = 1'b1;
         esc_phase_in = fud_pkg::ESC_IDLE;
      end else if (is_amp) begin
         esc_phase_in = fud_pkg::ESC_IDLE;
         pair_open_in = 1'b0;
         in_value_in  = 1'b0;
      end else if (is_name_eq) begin
         pair_open_in = 1'b1;
         in_value_in  = 1'b1;
         esc_phase_in = fud_pkg::ESC_IDLE;
      end else if (is_data) begin
         pair_open_in = 1'b1;
         case (esc_phase_ff)
            fud_pkg::ESC_PERCENT: begin
               esc_high_in  = fud_pkg::digit_value(byte_sp);
               esc_phase_in = fud_pkg::ESC_HIGH;
            end
            fud_pkg::ESC_HIGH: begin
               esc_phase_in = fud_pkg::ESC_IDLE;
            end
            default: begin
               esc_phase_in = (byte_sp == fud_pkg::CHAR_PERCENT) ?
                              fud_pkg::ESC_PERCENT : fud_pkg::ESC_IDLE;
            end
         endcase
      end
      if (req_tlast) begin
         pair_open_in = 1'b0;
         in_value_in  = 1'b0;
         esc_phase_in = fud_pkg::ESC_IDLE;
         esc_high_in  = '0;
         stopped_in   = 1'b0;
      end
   end

   // entry built from this byte
   always_comb begin
      entry           = '0;
      entry.data_kind = in_value_ff ? fud_pkg::KIND_VALUE : fud_pkg::KIND_NAME;
      if (is_data) begin
         case (esc_phase_ff)
            fud_pkg::ESC_PERCENT: begin
               entry.has_data = 1'b0;
            end
            fud_pkg::ESC_HIGH: begin
               entry.has_data = 1'b1;
               entry.data     = {esc_high_ff[3:0], 4'h0} + fud_pkg::digit_value(byte_sp);
            end
            default: begin
               entry.has_data = (byte_sp != fud_pkg::CHAR_PERCENT);
               entry.data     = byte_sp;
            end
         endcase
      end
      entry.has_pair = (is_amp && pair_open_ff) || (req_tlast && pair_open_mid);
      entry.has_end  = req_tlast;
   end

   assign push = accept && (entry.has_data || entry.has_pair || entry.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_open_ff <= 1'b0;
         in_value_ff  <= 1'b0;
         esc_phase_ff <= fud_pkg::ESC_IDLE;
         esc_high_ff  <= '0;
         stopped_ff   <= 1'b0;
      end else if (accept) begin
         pair_open_ff <= pair_open_in;
         in_value_ff  <= in_value_in;
         esc_phase_ff <= esc_phase_in;
         esc_high_ff  <= esc_high_in;
         stopped_ff   <= stopped_in;
      end
   end

endmodule

[hw/rtl/fud_queue.sv]
// Short entry queue between the front and back parts of the form body decoder.
// Depends on fud_pkg for the entry type.
module fud_queue #(
   parameter int Depth = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fud_pkg::entry_type push_entry,
   input  logic               pop,
   output fud_pkg::entry_type head,
   output logic               not_empty,
   output logic               full
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastSlot  = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   fud_pkg::entry_type        slots_ff [Depth];
   logic [PtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]     count_ff, count_in;
   logic                      do_push, do_pop;

   assign full      = (count_ff == FullCount);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count exceeds depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("front pushed into a full queue");

   a_empty_ptrs_equal: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with pointers apart");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

[hw/rtl/fud_back.sv]
// Back part of the form body decoder: walks the head entry one result per cycle, while
// the output register is free, into the output register. Depends on fud_pkg.
module fud_back (
   input  logic               clock,
   input  logic               reset,
   input  fud_pkg::entry_type head,
   input  logic               not_empty,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [7:0] decoded_byte
   output logic [1:0]         rsp_tuser,   // [1:0] item_kind
   output logic               rsp_tlast    // last_of_run
);

   logic                   valid_ff, valid_in;
   logic [7:0]             data_ff, data_in;
   fud_pkg::item_kind_type kind_ff, kind_in;
   logic                   last_ff, last_in;
   logic                   data_done_ff, data_done_in;
   logic                   pair_done_ff, pair_done_in;

   logic out_free, issue;
   logic pend_data, pend_pair, pend_end;

   assign out_free  = !valid_ff || rsp_tready;
   assign issue     = out_free && not_empty;
   assign pend_data = head.has_data && !data_done_ff;
   assign pend_pair = head.has_pair && !pair_done_ff;
   assign pend_end  = head.has_end;

   // pick the first pending result of the head entry
   always_comb begin
      data_in      = '0;
      kind_in      = fud_pkg::KIND_END;
      last_in      = 1'b1;
      data_done_in = data_done_ff;
      pair_done_in = pair_done_ff;
      if (pend_data) begin
         data_in      = head.data;
         kind_in      = head.data_kind;
         last_in      = !(pend_pair || pend_end);
         data_done_in = 1'b1;
      end else if (pend_pair) begin
         kind_in      = fud_pkg::KIND_PAIR;
         last_in      = !pend_end;
         pair_done_in = 1'b1;
      end
      if (last_in) begin
         data_done_in = 1'b0;
         pair_done_in = 1'b0;
      end
   end

   assign pop      = issue && last_in;
   assign valid_in = issue || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         data_done_ff <= 1'b0;
         pair_done_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (issue) begin
            data_done_ff <= data_done_in;
            pair_done_ff <= pair_done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         data_ff <= data_in;
         kind_ff <= kind_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule
